[sv/rtti_pkg.sv]
// Shared types, constants and character codes for the radix text-to-integer block.
package rtti_pkg;

    localparam int VALUE_BITS = 32;
    // Product width: value times a 6-bit radix, plus sign and margin.
    localparam int WIDE_BITS  = VALUE_BITS + 8;
    localparam int BASE_BITS  = 6;
    localparam int DIGIT_BITS = 6;

    localparam logic [BASE_BITS-1:0] BASE_RESET = BASE_BITS'(10);
    localparam logic [BASE_BITS-1:0] BASE_MIN   = BASE_BITS'(2);
    localparam logic [BASE_BITS-1:0] BASE_MAX   = BASE_BITS'(36);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] parsed_value;
        logic                         parse_error;
    } out_t;

    // Per-text parse state; the accumulator is always zero or negative.
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] acc;
        logic                         is_neg;
        logic                         err;
        logic                         first;
    } state_t;

    localparam state_t STATE_CLEAR = '{acc: '0, is_neg: 1'b0, err: 1'b0, first: 1'b1};

endpackage

[sv/radix_text_to_integer_core.sv]
// Top level of the radix text-to-integer parser.
//
// Usage:
//   in channel  : one text character per beat (text_byte, last_byte), valid/stall.
//   out channel : one result beat per text (parsed_value, parse_error),
//                 issued only for the beat flagged last_byte.
//   cfg channel : cfg_valid/cfg_ready write of number_base (radix 2..36);
//                 cfg_ready is always high. Write only while the block is idle.
// Throughput: one character per cycle, sustained unless a last character waits behind a stalled result.
// A character taken into the input register is parsed into the parse state and,
//   for a last character, into the result register, from which its result beat
//   is then offered.
// The parse step between the input register and the state is one 32x6
//   multiply, one subtract and one compare.
// Reset: radix returns to 10, parse state clears, both registers go empty.
// Stall: a stalled result holds in the result register. Characters that end
//   no text keep flowing into the parse state; a last character waiting behind
//   a stalled result holds the input register and raises in_stall.
// Errors (bad sign, bad digit, bad radix, overflow) are sticky until the last
//   character, which then returns -1 with parse_error set.
module radix_text_to_integer_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  rtti_pkg::in_t                   in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output rtti_pkg::out_t                  out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rtti_pkg::BASE_BITS-1:0]  cfg_data
);
    import rtti_pkg::*;

    // Radix register.
    logic [BASE_BITS-1:0] base_reg;

    // Input register.
    logic   in_valid_reg;
    logic   in_valid_next;
    in_t    in_reg;

    // Parse state.
    state_t st_reg;
    state_t st_next;

    out_t   step_res;
    logic   out_free;
    logic   advance;   // input register beat is consumed this cycle
    logic   take;      // new beat accepted this cycle
    logic   emit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            base_reg <= cfg_data;
        end
    end

    // A non-last beat never needs the result register.
    assign advance       = in_valid_reg && (!in_reg.last_byte || out_free);
    assign in_stall      = in_valid_reg && !advance;
    assign take          = in_valid && !in_stall;
    assign in_valid_next = take ? 1'b1 : (in_valid_reg && !advance);
    assign emit          = advance && in_reg.last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_reg <= in_data;
        end
    end

    rtti_step u_step (
        .st      (st_reg),
        .item    (in_reg),
        .base    (base_reg),
        .st_next (st_next),
        .res     (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= STATE_CLEAR;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

    rtti_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit),
        .load_data (step_res),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Accumulator is built as a negative number: never positive.
    assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.acc[VALUE_BITS-1] || (st_reg.acc == '0))
        else $error("accumulator went positive");

    // An error result always carries -1.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.parse_error |-> (out_data.parsed_value == '1))
        else $error("error result without -1 value");

    // Finishing a text returns the parse state to its cleared form.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (st_reg.first && !st_reg.err && !st_reg.is_neg && st_reg.acc == '0))
        else $error("parse state not cleared after last byte");

    // A last beat that is consumed always finds the result register free.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result overwritten while stalled");

endmodule

[sv/rtti_step.sv]
// Next-state and result logic for one character of the number text.
module rtti_step (
    input  rtti_pkg::state_t               st,
    input  rtti_pkg::in_t                  item,
    input  logic [rtti_pkg::BASE_BITS-1:0] base,
    output rtti_pkg::state_t               st_next,
    output rtti_pkg::out_t                 res
);
    import rtti_pkg::*;

    logic [7:0]                   c;
    logic [DIGIT_BITS-1:0]        digit;
    logic                         is_digit;
    logic                         digit_ok;
    logic                         bad_base;
    logic                         is_sign;
    logic signed [WIDE_BITS-1:0]  prod;
    logic signed [WIDE_BITS-1:0]  cand;
    logic signed [WIDE_BITS-1:0]  limit;
    logic                         ovf;
    state_t                       upd;

    assign c = item.text_byte;

    always_comb
    begin
        digit    = '0;
        is_digit = 1'b0;
        if (c >= CH_LA && c <= CH_LZ)
        begin
            digit    = DIGIT_BITS'(c - CH_LA) + DIGIT_BITS'(10);
            is_digit = 1'b1;
        end
        else if (c >= CH_UA && c <= CH_UZ)
        begin
            digit    = DIGIT_BITS'(c - CH_UA) + DIGIT_BITS'(10);
            is_digit = 1'b1;
        end
        else if (c >= CH_0 && c <= CH_9)
        begin
            digit    = DIGIT_BITS'(c - CH_0);
            is_digit = 1'b1;
        end
    end

    assign digit_ok = is_digit && (digit < base);
    assign bad_base = (base < BASE_MIN) || (base > BASE_MAX);
    assign is_sign  = st.first && (c == CH_PLUS || c == CH_MINUS);

    // acc*base - digit < limit covers both the acc < limit/base test
    // and the post-multiply test.
    assign prod  = $signed({{(WIDE_BITS-VALUE_BITS){st.acc[VALUE_BITS-1]}}, st.acc})
                 * $signed({{(WIDE_BITS-BASE_BITS){1'b0}}, base});
    assign cand  = prod - $signed({{(WIDE_BITS-DIGIT_BITS){1'b0}}, digit});
    assign limit = $signed({{(WIDE_BITS-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}})
                 + $signed({{(WIDE_BITS-1){1'b0}}, !st.is_neg});
    assign ovf   = cand < limit;

    always_comb
    begin
        upd       = st;
        upd.first = 1'b0;
        if (!st.err)
        begin
            if (bad_base)
            begin
                upd.err = 1'b1;
            end
            else if (is_sign)
            begin
                upd.is_neg = (c == CH_MINUS);
                if (item.last_byte)
                begin
                    upd.err = 1'b1;
                end
            end
            else if (!digit_ok || ovf)
            begin
                upd.err = 1'b1;
            end
            else
            begin
                upd.acc = cand[VALUE_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        res.parse_error = upd.err;
        if (upd.err)
        begin
            res.parsed_value = '1;
        end
        else if (upd.is_neg)
        begin
            res.parsed_value = upd.acc;
        end
        else
        begin
            res.parsed_value = -upd.acc;
        end
        st_next = item.last_byte ? STATE_CLEAR : upd;
    end

endmodule

[sv/rtti_out_stage.sv]
// Result register with valid/stall handshake toward the receiver.
module rtti_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  rtti_pkg::out_t load_data,
    output logic           free,
    output logic           out_valid,
    input  logic           out_stall,
    output rtti_pkg::out_t out_data
);
    import rtti_pkg::*;

    logic valid_reg;
    logic valid_next;
    out_t data_reg;

    assign free       = !valid_reg || !out_stall;
    assign valid_next = load ? 1'b1 : (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[test/testbench.sv]
// Self-checking testbench for radix_text_to_integer_core: directed texts, then random phases.
import rtti_pkg::*;

// Tracks the parse state of the block, holds the values it must return, and checks them.
class parse_scoreboard;
    logic [BASE_BITS-1:0] radix;
    longint               acc;
    bit                   neg;
    bit                   err;
    bit                   first;
    out_t                 pending[$];
    int                   mismatches;

    function new();
        radix      = BASE_RESET;
        mismatches = 0;
        clear_text();
    endfunction

    function void clear_text();
        acc   = 0;
        neg   = 1'b0;
        err   = 1'b0;
        first = 1'b1;
    endfunction

    function void set_radix(logic [BASE_BITS-1:0] v);
        radix = v;
    endfunction

    // Digit value of a character in the current radix, -1 if it is none.
    function int digit_value(logic [7:0] c);
        int d;
        d = -1;
        if (c >= CH_LA && c <= CH_LZ) d = int'(c - CH_LA) + 10;
        else if (c >= CH_UA && c <= CH_UZ) d = int'(c - CH_UA) + 10;
        else if (c >= CH_0 && c <= CH_9) d = int'(c - CH_0);
        if (d >= 0 && d < int'(radix)) return d;
        return -1;
    endfunction

    function void note_input(in_t b);
        longint r;
        longint top;
        longint lim;
        longint m;
        longint t;
        longint v;
        int     d;
        bit     was_first;
        out_t   e;
        r         = longint'(radix);
        top       = (longint'(1) << (VALUE_BITS - 1)) - 1;
        was_first = first;
        first     = 1'b0;
        if (!err) begin
            if (r < 2 || r > 36) begin
                err = 1'b1;
            end
            else if (was_first && (b.text_byte == CH_PLUS || b.text_byte == CH_MINUS)) begin
                neg = (b.text_byte == CH_MINUS);
                if (b.last_byte) err = 1'b1;
            end
            else begin
                // value is built negative; check before multiply and before subtract
                lim = neg ? (-top - 1) : -top;
                m   = lim / r;
                d   = digit_value(b.text_byte);
                if (d < 0 || acc < m) begin
                    err = 1'b1;
                end
                else begin
                    t = acc * r;
                    if (t < lim + longint'(d)) err = 1'b1;
                    else acc = t - longint'(d);
                end
            end
        end
        if (b.last_byte) begin
            if (err) v = -1;
            else v = neg ? acc : -acc;
            e.parsed_value = VALUE_BITS'(v);
            e.parse_error  = err;
            pending.push_back(e);
            clear_text();
        end
    endfunction

    task report(string what);
        if (mismatches < 100) $display("mismatch: %s", what);
        mismatches++;
    endtask

    task check_result(out_t r);
        out_t e;
        if (pending.size() == 0) begin
            report($sformatf("result %0d/%0b with none expected", r.parsed_value, r.parse_error));
        end
        else begin
            e = pending.pop_front();
            if (r.parsed_value !== e.parsed_value)
                report($sformatf("parsed_value %0d, expected %0d", r.parsed_value,
                                 e.parsed_value));
            if (r.parse_error !== e.parse_error)
                report($sformatf("parse_error %b, expected %b", r.parse_error, e.parse_error));
        end
    endtask
endclass

module testbench;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_BYTES    = 175;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_t                  in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_t                 out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [BASE_BITS-1:0] cfg_data  = '0;

    parse_scoreboard sb = new();
    logic [7:0]      text_q[$];
    int              send_pct  = 0;
    int              stall_pct = 0;
    int              idle_count = 0;

    radix_text_to_integer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: check each taken beat, then pick the stall for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Watchdog: counts cycles in which no beat moves on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_count <= 0;
        else if (idle_count + 1 >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_count <= idle_count + 1;
    end

    // One character beat; gaps before it at the sender idle rate.
    task send_byte(in_t b);
        while (send_pct != 0 && $urandom_range(99) < send_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (in_stall);
        sb.note_input(b);
    endtask

    // Sends text_q; the last character carries the last flag when end_it is set.
    task send_text(bit end_it);
        in_t b;
        for (int i = 0; i < text_q.size(); i++) begin
            b.text_byte = text_q[i];
            b.last_byte = end_it && (i == text_q.size() - 1);
            send_byte(b);
        end
    endtask

    // Drop valid, wait for every expected result, then let the parse step settle.
    task wait_idle();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_radix(logic [BASE_BITS-1:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_radix(v);
    endtask

    task put_text(string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] digit_char(int d, bit upper);
        if (d < 10) return CH_0 + 8'(d);
        return (upper ? CH_UA : CH_LA) + 8'(d - 10);
    endfunction

    // Digits needed for 2^31 in radix r.
    function automatic int digits_for(int r);
        longint v = longint'(1) << 31;
        int     n = 0;
        while (v > 0) begin
            v = v / r;
            n++;
        end
        return n;
    endfunction

    function automatic void push_sign();
        case ($urandom_range(2))
            1: text_q.push_back(CH_PLUS);
            2: text_q.push_back(CH_MINUS);
            default: ;
        endcase
    endfunction

    // Builds one random text into text_q; mostly well formed, some near the limits,
    // some noise and some with a bad character inside.
    task make_random_text();
        int     r;
        int     kind;
        int     len;
        int     p;
        longint mag;
        logic [7:0] digs[$];
        r = int'(sb.radix);
        if (r < 2 || r > 36) r = 10;
        kind = $urandom_range(99);
        text_q.delete();
        if (kind < 15) begin
            case ($urandom_range(4))
                0: mag = (longint'(1) << 31) - 1;
                1: mag = longint'(1) << 31;
                2: mag = (longint'(1) << 31) + 1;
                3: mag = (longint'(1) << 31) - $urandom_range(1000, 1);
                default: mag = (longint'(1) << 31) + $urandom_range(1000, 1);
            endcase
            push_sign();
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(3, 1)) text_q.push_back(CH_0);
            digs.delete();
            while (mag > 0) begin
                digs.push_front(digit_char(int'(mag % r), $urandom_range(1)));
                mag = mag / r;
            end
            foreach (digs[i]) text_q.push_back(digs[i]);
        end
        else if (kind < 90 && kind >= 80) begin
            repeat ($urandom_range(6, 1)) text_q.push_back(8'($urandom_range(255)));
        end
        else begin
            if ($urandom_range(9) < 3) push_sign();
            if ($urandom_range(1)) len = $urandom_range(digits_for(r) / 2 + 1, 1);
            else len = $urandom_range(digits_for(r) + 1, 1);
            repeat (len) text_q.push_back(digit_char($urandom_range(r - 1), $urandom_range(1)));
            if (kind >= 90 && text_q.size() > 1) begin
                // corrupt one character after the first
                p = $urandom_range(text_q.size() - 1, 1);
                case ($urandom_range(3))
                    0: text_q[p] = CH_PLUS;
                    1: text_q[p] = CH_MINUS;
                    2: text_q[p] = (r < 36) ? digit_char($urandom_range(35, r), $urandom_range(1))
                                            : 8'h2F;
                    default: text_q[p] = 8'($urandom_range(255));
                endcase
            end
        end
    endtask

    initial
    begin
        int phase_radix[8] = '{2, 36, 10, 16, 0, 8, 0, 36};
        int phase_bytes;
        logic [BASE_BITS-1:0] r;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset radix of ten: lone signs, sign later, sticky error.
        put_text("+");
        send_text(1);
        put_text("-");
        send_text(1);
        put_text("1-");
        send_text(1);
        put_text("x5");
        send_text(1);
        text_q = '{8'h00};
        send_text(1);
        text_q = '{8'hFF};
        send_text(1);

        // Radix 36: letter first and both signed limits.
        write_radix(BASE_MAX);
        put_text("Z");
        send_text(1);
        put_text("zik0zj");
        send_text(1);
        put_text("-ZIK0ZK");
        send_text(1);

        // Radix change in the middle of a text: 'f' must count as fifteen.
        put_text("1");
        send_text(0);
        write_radix(6'd16);
        put_text("f");
        send_text(1);

        // Radix out of range, low and high.
        write_radix(6'd0);
        put_text("5");
        send_text(1);
        write_radix(6'd63);
        put_text("1");
        send_text(1);

        // Random phases; the idle pattern cycles through all four mixes.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_pct = 0;  stall_pct = 0;  end
                1: begin send_pct = 59; stall_pct = 0;  end
                2: begin send_pct = 0;  stall_pct = 59; end
                default: begin send_pct = 31; stall_pct = 31; end
            endcase
            if (phase_radix[ph] == 0) r = BASE_BITS'($urandom_range(35, 3));
            else r = BASE_BITS'(phase_radix[ph]);
            write_radix(r);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                make_random_text();
                phase_bytes += text_q.size();
                send_text(1);
            end
        end

        wait_idle();
        stall_pct = 0;
        repeat (8) @(posedge clk);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d expected results never came", sb.pending.size()));
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
